/* hdl/mmts_pkg.sv */
// Package: scanner state codes, token kinds, transition and kind functions.
package mmts_pkg;

  localparam int MaxLineLength = 4096;
  localparam int ColLimitI = (MaxLineLength - 1 > 4095) ? 4095 : MaxLineLength - 1;
  localparam logic [11:0] ColLimit = 12'(ColLimitI);
  localparam logic [12:0] MaxLen = 13'(MaxLineLength);

  localparam logic [5:0] NoKind = 6'd63;
  localparam logic [5:0] SpaceKind = 6'd34;

  typedef enum logic [6:0] {
    Q_NONE, Q_START,
    Q_R, Q_RE, Q_RET, Q_RETU, Q_RETUR, Q_RETURN,
    Q_W, Q_WH, Q_WHI, Q_WHIL, Q_WHILE, Q_WA, Q_WAI, Q_WAIN,
    Q_I, Q_IN, Q_INT, Q_IF,
    Q_E, Q_EL, Q_ELS, Q_ELSE,
    Q_P, Q_PR, Q_PRI, Q_PRIN, Q_PRINT, Q_PRINTL, Q_PRINTLN,
    Q_N, Q_NU, Q_NUL, Q_NULL, Q_NE, Q_NEW,
    Q_D, Q_DE, Q_DEL, Q_DELE, Q_DELET, Q_DELETE,
    Q_ID, Q_ZERO, Q_NUM,
    Q_LPAREN, Q_RPAREN, Q_LBRACE, Q_RBRACE, Q_LBRACK, Q_RBRACK, Q_AMP,
    Q_BECOMES, Q_EQ, Q_BANG, Q_NEQ, Q_LT, Q_GT, Q_LE, Q_GE,
    Q_PLUS, Q_MINUS, Q_STAR, Q_SLASH, Q_PCT, Q_COMMA, Q_SEMI,
    Q_COMMENT, Q_SPACE
  } state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] col;
    logic [12:0] len;
    logic        err;
  } res_t;

  // one queued request: up to two results
  typedef struct packed {
    logic  v0;
    res_t  r0;
    logic  v1;
    res_t  r1;
  } pair_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic state_t trie(state_t s, logic [7:0] b);
    state_t t;
    t = Q_NONE;
    unique case (s)
      Q_START: begin
        unique case (b)
          "r": t = Q_R;
          "d": t = Q_D;
          "e": t = Q_E;
          "i": t = Q_I;
          "p": t = Q_P;
          "N", "n": t = Q_N;
          "w": t = Q_W;
          default: t = Q_NONE;
        endcase
      end
      Q_R:      if (b == "e") t = Q_RE;
      Q_RE:     if (b == "t") t = Q_RET;
      Q_RET:    if (b == "u") t = Q_RETU;
      Q_RETU:   if (b == "r") t = Q_RETUR;
      Q_RETUR:  if (b == "n") t = Q_RETURN;
      Q_D:      if (b == "e") t = Q_DE;
      Q_DE:     if (b == "l") t = Q_DEL;
      Q_DEL:    if (b == "e") t = Q_DELE;
      Q_DELE:   if (b == "t") t = Q_DELET;
      Q_DELET:  if (b == "e") t = Q_DELETE;
      Q_E:      if (b == "l") t = Q_EL;
      Q_EL:     if (b == "s") t = Q_ELS;
      Q_ELS:    if (b == "e") t = Q_ELSE;
      Q_I: begin
        if (b == "f") t = Q_IF;
        else if (b == "n") t = Q_IN;
      end
      Q_IN:     if (b == "t") t = Q_INT;
      Q_P:      if (b == "r") t = Q_PR;
      Q_PR:     if (b == "i") t = Q_PRI;
      Q_PRI:    if (b == "n") t = Q_PRIN;
      Q_PRIN:   if (b == "t") t = Q_PRINT;
      Q_PRINT:  if (b == "l") t = Q_PRINTL;
      Q_PRINTL: if (b == "n") t = Q_PRINTLN;
      Q_N: begin
        if (b == "U") t = Q_NU;
        else if (b == "e") t = Q_NE;
      end
      Q_NU:     if (b == "L") t = Q_NUL;
      Q_NUL:    if (b == "L") t = Q_NULL;
      Q_NE:     if (b == "w") t = Q_NEW;
      Q_W: begin
        if (b == "a") t = Q_WA;
        else if (b == "h") t = Q_WH;
      end
      Q_WA:     if (b == "i") t = Q_WAI;
      Q_WAI:    if (b == "n") t = Q_WAIN;
      Q_WH:     if (b == "i") t = Q_WHI;
      Q_WHI:    if (b == "l") t = Q_WHIL;
      Q_WHIL:   if (b == "e") t = Q_WHILE;
      default:  t = Q_NONE;
    endcase
    return t;
  endfunction

  function automatic state_t start_next(logic [7:0] b);
    state_t t;
    t = Q_NONE;
    if (is_space(b)) t = Q_SPACE;
    else if (b == "0") t = Q_ZERO;
    else if (is_digit(b)) t = Q_NUM;
    else if (is_letter(b)) begin
      t = trie(Q_START, b);
      if (t == Q_NONE) t = Q_ID;
    end else begin
      unique case (b)
        "(": t = Q_LPAREN;  ")": t = Q_RPAREN;
        "{": t = Q_LBRACE;  "}": t = Q_RBRACE;
        "[": t = Q_LBRACK;  "]": t = Q_RBRACK;
        "&": t = Q_AMP;     "=": t = Q_BECOMES;
        "!": t = Q_BANG;    "<": t = Q_LT;
        ">": t = Q_GT;      "+": t = Q_PLUS;
        "-": t = Q_MINUS;   "*": t = Q_STAR;
        "/": t = Q_SLASH;   "%": t = Q_PCT;
        ",": t = Q_COMMA;   ";": t = Q_SEMI;
        default: t = Q_NONE;
      endcase
    end
    return t;
  endfunction

  function automatic state_t cont_next(state_t s, logic [7:0] b);
    state_t t;
    t = Q_NONE;
    if (s >= Q_R && s <= Q_ID) begin
      t = trie(s, b);
      if (t == Q_NONE && (is_letter(b) || is_digit(b))) t = Q_ID;
    end else begin
      unique case (s)
        Q_SPACE:   t = is_space(b) ? Q_SPACE : Q_NONE;
        Q_NUM:     t = is_digit(b) ? Q_NUM : Q_NONE;
        Q_BECOMES: t = (b == "=") ? Q_EQ : Q_NONE;
        Q_BANG:    t = (b == "=") ? Q_NEQ : Q_NONE;
        Q_LT:      t = (b == "=") ? Q_LE : Q_NONE;
        Q_GT:      t = (b == "=") ? Q_GE : Q_NONE;
        Q_SLASH:   t = (b == "/") ? Q_COMMENT : Q_NONE;
        Q_COMMENT: t = Q_COMMENT;
        default:   t = Q_NONE;
      endcase
    end
    return t;
  endfunction

  function automatic logic [5:0] kind_of(state_t s);
    logic [5:0] k;
    unique case (s)
      Q_RETURN:  k = 6'd11;
      Q_WHILE:   k = 6'd14;
      Q_WAIN:    k = 6'd16;
      Q_INT:     k = 6'd20;
      Q_IF:      k = 6'd12;
      Q_ELSE:    k = 6'd13;
      Q_PRINTLN: k = 6'd15;
      Q_NULL:    k = 6'd10;
      Q_NEW:     k = 6'd17;
      Q_DELETE:  k = 6'd18;
      Q_ZERO:    k = 6'd2;
      Q_NUM:     k = 6'd1;
      Q_LPAREN:  k = 6'd3;
      Q_RPAREN:  k = 6'd4;
      Q_LBRACE:  k = 6'd5;
      Q_RBRACE:  k = 6'd6;
      Q_LBRACK:  k = 6'd7;
      Q_RBRACK:  k = 6'd8;
      Q_AMP:     k = 6'd9;
      Q_BECOMES: k = 6'd19;
      Q_EQ:      k = 6'd21;
      Q_NEQ:     k = 6'd22;
      Q_LT:      k = 6'd23;
      Q_GT:      k = 6'd24;
      Q_LE:      k = 6'd25;
      Q_GE:      k = 6'd26;
      Q_PLUS:    k = 6'd27;
      Q_MINUS:   k = 6'd28;
      Q_STAR:    k = 6'd29;
      Q_SLASH:   k = 6'd30;
      Q_PCT:     k = 6'd31;
      Q_COMMA:   k = 6'd32;
      Q_SEMI:    k = 6'd33;
      Q_COMMENT: k = 6'd37;
      Q_SPACE:   k = SpaceKind;
      Q_NONE, Q_START, Q_BANG: k = NoKind;
      default:   k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

/* hdl/mmts_if.sv */
// Interfaces: byte input channel and token result channel.
interface mmts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;
  modport source (output valid, char_byte, line_end, input ready);
  modport sink (input valid, char_byte, line_end, output ready);
endinterface

interface mmts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [11:0] start_column;
  logic [12:0] token_length;
  logic        lex_error;
  logic        last;
  modport source (output valid, token_kind, start_column, token_length, lex_error, last,
                  input ready);
  modport sink (input valid, token_kind, start_column, token_length, lex_error, last,
                output ready);
endinterface

/* hdl/maximal_munch_token_scanner.sv */
// Top level: maximal-munch token scanner.
//   channel  dir  payload
//   in_      in   char_byte, line_end
//   out_     out  token_kind, start_column, token_length, lex_error, last
// One byte per cycle while the queue is not full; the automaton steps in the front end in the accept cycle.
// A byte that causes two results is sent out by the back end as two separate results.
// Results pass through the queue and then the back end's output register.
// Reset is synchronous; a four-deep queue absorbs output stalls.
module maximal_munch_token_scanner
  import mmts_pkg::*;
(
  input logic clk,
  input logic rst_n,
  mmts_in_if.sink    in_ch,
  mmts_out_if.source out_ch
);

  logic  push, full, pop, ne;
  pair_t pd, head;

  mmts_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_char_byte(in_ch.char_byte), .in_line_end(in_ch.line_end),
    .push, .push_data(pd), .q_full(full)
  );

  mmts_queue u_queue (
    .clk, .rst_n, .push, .push_data(pd), .full,
    .pop, .not_empty(ne), .head
  );

  mmts_back u_back (
    .clk, .rst_n, .q_valid(ne), .q_head(head), .pop, .out_ch
  );

endmodule

/* hdl/mmts_front.sv */
// Front end: automaton step per byte, forms up to two results per request.
module mmts_front
  import mmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_line_end,
  output logic       push,
  output pair_t      push_data,
  input  logic       q_full
);

  state_t      st_r, st_nxt;
  logic [11:0] tsc_r, tsc_nxt;
  logic [11:0] col_r, col_nxt;
  logic        skip_r, skip_nxt;

  state_t     nx, nx0, fs;
  logic       err;
  logic [5:0] k, kf;
  logic [11:0] cp1;
  res_t       a, bres;
  logic       av, bv;

  assign in_ready = !q_full;
  assign cp1 = (col_r < 12'd4095) ? col_r + 12'd1 : 12'd4095;

  // hold token lengths between one and the line limit
  function automatic logic [12:0] sat_len(logic [12:0] l);
    return (l == 13'd0) ? 13'd1 : ((l > MaxLen) ? MaxLen : l);
  endfunction

  always_comb begin
    st_nxt = st_r;
    tsc_nxt = tsc_r;
    col_nxt = col_r;
    skip_nxt = skip_r;
    err = 1'b0;
    av = 1'b0;
    bv = 1'b0;
    a = '0;
    bres = '0;
    nx0 = start_next(in_char_byte);
    nx = (st_r == Q_START) ? nx0 : cont_next(st_r, in_char_byte);
    k = kind_of(st_r);
    fs = Q_START;
    kf = NoKind;
    if (skip_r) begin
      if (in_line_end) begin
        st_nxt = Q_START; tsc_nxt = '0; col_nxt = '0; skip_nxt = 1'b0;
      end else if (col_r < ColLimit) begin
        col_nxt = col_r + 12'd1;
      end
    end else begin
      if (nx == Q_NONE) begin
        if (st_r != Q_START) begin
          if (k == NoKind) begin
            av = 1'b1; err = 1'b1;
            a = '{kind: '0, col: col_r, len: '0, err: 1'b1};
          end else if (k != SpaceKind) begin
            av = 1'b1;
            a = '{kind: k, col: tsc_r, len: sat_len(13'(col_r - tsc_r)), err: 1'b0};
          end
        end
        if (!err) begin
          tsc_nxt = col_r;
          nx = nx0;
          if (nx0 == Q_NONE) begin
            err = 1'b1;
            bv = 1'b1;
            bres = '{kind: '0, col: col_r, len: '0, err: 1'b1};
          end
        end
      end
      fs = err ? Q_START : nx;
      st_nxt = fs;
      skip_nxt = err;
      kf = kind_of(fs);
      if (in_line_end) begin
        if (!err) begin
          if (fs == Q_BANG) begin
            bv = 1'b1;
            bres = '{kind: '0, col: cp1, len: '0, err: 1'b1};
          end else if (kf != NoKind && kf != SpaceKind) begin
            bv = 1'b1;
            bres = '{kind: kf, col: tsc_nxt,
                     len: sat_len(13'({1'b0, col_r} + 13'd1 - {1'b0, tsc_nxt})),
                     err: 1'b0};
          end
        end
        st_nxt = Q_START; tsc_nxt = '0; col_nxt = '0; skip_nxt = 1'b0;
      end else if (col_r < ColLimit) begin
        col_nxt = col_r + 12'd1;
      end
    end
  end

  assign push = in_valid && in_ready && (av || bv);
  assign push_data = '{v0: av, r0: a, v1: bv, r1: bres};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= Q_START;
      tsc_r <= '0;
      col_r <= '0;
      skip_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_r <= st_nxt;
      tsc_r <= tsc_nxt;
      col_r <= col_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

/* hdl/mmts_queue.sv */
// Queue: short FIFO of result pairs between front and back.
module mmts_queue
  import mmts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pair_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output pair_t head
);

  pair_t      mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full = cnt_r == 3'd4;
  assign not_empty = cnt_r != 3'd0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

endmodule

/* hdl/mmts_back.sv */
// Back end: unpacks a pair into single results through an output register.
module mmts_back
  import mmts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  pair_t q_head,
  output logic  pop,
  mmts_out_if.source out_ch
);

  logic  sel_r;
  logic  ov_r;
  res_t  or_r;
  logic  ol_r;
  logic  load;
  logic  use1, lastp;
  res_t  pick;

  // second half pending when first taken
  assign use1 = sel_r || !q_head.v0;
  assign pick = use1 ? q_head.r1 : q_head.r0;
  assign lastp = use1 || !q_head.v1;
  assign load = q_valid && (!ov_r || out_ch.ready);
  assign pop = load && lastp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        sel_r <= !lastp;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      or_r <= pick;
      ol_r <= lastp;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.token_kind = or_r.kind;
  assign out_ch.start_column = or_r.col;
  assign out_ch.token_length = or_r.len;
  assign out_ch.lex_error = or_r.err;
  assign out_ch.last = ol_r;

endmodule

/* verif/tb_token_scanner.sv */
// Testbench: drives byte streams into the token scanner and checks every result.
module testbench;
  import mmts_pkg::*;

  typedef struct packed {
    logic [5:0]  kind;
    logic [11:0] col;
    logic [12:0] len;
    logic        err;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    logic       has_tok;
    token_t     tok;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  mmts_in_if in_ch();
  mmts_out_if out_ch();

  maximal_munch_token_scanner dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  state_t     lex_state;
  logic [11:0] tok_col;
  logic [11:0] cur_col;
  logic        skipping;
  token_t      pending_tokens[$];
  int          mismatches = 0;
  int          row_errors;
  int          cycles = 0;
  int          hold_off;
  int          rx_wait;
  bit          hold_req;
  bit          hold_used;
  string       words[$];

  function automatic logic letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction
  function automatic logic digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic blank(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic state_t word_step(state_t s, logic [7:0] b);
    case (s)
      Q_START: case (b)
        "r": return Q_R; "d": return Q_D; "e": return Q_E; "i": return Q_I;
        "p": return Q_P; "N", "n": return Q_N; "w": return Q_W;
        default: return Q_NONE;
      endcase
      Q_R: return b == "e" ? Q_RE : Q_NONE;
      Q_RE: return b == "t" ? Q_RET : Q_NONE;
      Q_RET: return b == "u" ? Q_RETU : Q_NONE;
      Q_RETU: return b == "r" ? Q_RETUR : Q_NONE;
      Q_RETUR: return b == "n" ? Q_RETURN : Q_NONE;
      Q_D: return b == "e" ? Q_DE : Q_NONE;
      Q_DE: return b == "l" ? Q_DEL : Q_NONE;
      Q_DEL: return b == "e" ? Q_DELE : Q_NONE;
      Q_DELE: return b == "t" ? Q_DELET : Q_NONE;
      Q_DELET: return b == "e" ? Q_DELETE : Q_NONE;
      Q_E: return b == "l" ? Q_EL : Q_NONE;
      Q_EL: return b == "s" ? Q_ELS : Q_NONE;
      Q_ELS: return b == "e" ? Q_ELSE : Q_NONE;
      Q_I: return b == "f" ? Q_IF : (b == "n" ? Q_IN : Q_NONE);
      Q_IN: return b == "t" ? Q_INT : Q_NONE;
      Q_P: return b == "r" ? Q_PR : Q_NONE;
      Q_PR: return b == "i" ? Q_PRI : Q_NONE;
      Q_PRI: return b == "n" ? Q_PRIN : Q_NONE;
      Q_PRIN: return b == "t" ? Q_PRINT : Q_NONE;
      Q_PRINT: return b == "l" ? Q_PRINTL : Q_NONE;
      Q_PRINTL: return b == "n" ? Q_PRINTLN : Q_NONE;
      Q_N: return b == "U" ? Q_NU : (b == "e" ? Q_NE : Q_NONE);
      Q_NU: return b == "L" ? Q_NUL : Q_NONE;
      Q_NUL: return b == "L" ? Q_NULL : Q_NONE;
      Q_NE: return b == "w" ? Q_NEW : Q_NONE;
      Q_W: return b == "a" ? Q_WA : (b == "h" ? Q_WH : Q_NONE);
      Q_WA: return b == "i" ? Q_WAI : Q_NONE;
      Q_WAI: return b == "n" ? Q_WAIN : Q_NONE;
      Q_WH: return b == "i" ? Q_WHI : Q_NONE;
      Q_WHI: return b == "l" ? Q_WHIL : Q_NONE;
      Q_WHIL: return b == "e" ? Q_WHILE : Q_NONE;
      default: return Q_NONE;
    endcase
  endfunction

  function automatic state_t advance(state_t s, logic [7:0] b);
    state_t t;
    if (s == Q_START) begin
      if (blank(b)) return Q_SPACE;
      if (b == "0") return Q_ZERO;
      if (digit(b)) return Q_NUM;
      if (letter(b)) begin
        t = word_step(s, b);
        return t != Q_NONE ? t : Q_ID;
      end
      case (b)
        "(": return Q_LPAREN; ")": return Q_RPAREN; "{": return Q_LBRACE;
        "}": return Q_RBRACE; "[": return Q_LBRACK; "]": return Q_RBRACK;
        "&": return Q_AMP; "=": return Q_BECOMES; "!": return Q_BANG;
        "<": return Q_LT; ">": return Q_GT; "+": return Q_PLUS;
        "-": return Q_MINUS; "*": return Q_STAR; "/": return Q_SLASH;
        "%": return Q_PCT; ",": return Q_COMMA; ";": return Q_SEMI;
        default: return Q_NONE;
      endcase
    end
    if (s >= Q_R && s <= Q_ID) begin
      t = word_step(s, b);
      if (t != Q_NONE) return t;
      return (letter(b) || digit(b)) ? Q_ID : Q_NONE;
    end
    case (s)
      Q_SPACE: return blank(b) ? Q_SPACE : Q_NONE;
      Q_NUM: return digit(b) ? Q_NUM : Q_NONE;
      Q_BECOMES: return b == "=" ? Q_EQ : Q_NONE;
      Q_BANG: return b == "=" ? Q_NEQ : Q_NONE;
      Q_LT: return b == "=" ? Q_LE : Q_NONE;
      Q_GT: return b == "=" ? Q_GE : Q_NONE;
      Q_SLASH: return b == "/" ? Q_COMMENT : Q_NONE;
      Q_COMMENT: return Q_COMMENT;
      default: return Q_NONE;
    endcase
  endfunction

  function automatic logic [5:0] token_kind_of(state_t s);
    case (s)
      Q_RETURN: return 6'd11; Q_WHILE: return 6'd14; Q_WAIN: return 6'd16;
      Q_INT: return 6'd20; Q_IF: return 6'd12; Q_ELSE: return 6'd13;
      Q_PRINTLN: return 6'd15; Q_NULL: return 6'd10; Q_NEW: return 6'd17;
      Q_DELETE: return 6'd18; Q_ZERO: return 6'd2; Q_NUM: return 6'd1;
      Q_LPAREN: return 6'd3; Q_RPAREN: return 6'd4; Q_LBRACE: return 6'd5;
      Q_RBRACE: return 6'd6; Q_LBRACK: return 6'd7; Q_RBRACK: return 6'd8;
      Q_AMP: return 6'd9; Q_BECOMES: return 6'd19; Q_EQ: return 6'd21;
      Q_NEQ: return 6'd22; Q_LT: return 6'd23; Q_GT: return 6'd24;
      Q_LE: return 6'd25; Q_GE: return 6'd26; Q_PLUS: return 6'd27;
      Q_MINUS: return 6'd28; Q_STAR: return 6'd29; Q_SLASH: return 6'd30;
      Q_PCT: return 6'd31; Q_COMMA: return 6'd32; Q_SEMI: return 6'd33;
      Q_COMMENT: return 6'd37; Q_SPACE: return SpaceKind;
      Q_NONE, Q_START, Q_BANG: return NoKind;
      default: return 6'd0;
    endcase
  endfunction

  function automatic token_t make_tok(logic [5:0] k, logic [11:0] c, int n, logic e);
    token_t t;
    if (n < 1 && !e) n = 1;
    if (n > MaxLineLength) n = MaxLineLength;
    t.kind = k;
    t.col = c;
    t.len = 13'(n);
    t.err = e;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_t with_last(token_t t);
    t.last = 1'b1;
    return t;
  endfunction

  function automatic void clear_line();
    lex_state = Q_START;
    tok_col = '0;
    cur_col = '0;
    skipping = 1'b0;
  endfunction

  // append results of one byte to the expected-token queue
  task automatic predict_tokens(logic [7:0] b, logic eol, output int n);
    token_t     outs[$];
    state_t     s, nx;
    logic [5:0] k;
    logic       failed;
    failed = 1'b0;
    s = lex_state;
    if (skipping) begin
      if (eol) clear_line();
      else if (cur_col < ColLimit) cur_col++;
      n = 0;
      return;
    end
    nx = advance(s, b);
    if (nx == Q_NONE) begin
      if (s != Q_START) begin
        k = token_kind_of(s);
        if (k == NoKind) begin
          outs = {outs, make_tok(6'd0, cur_col, 0, 1'b1)};
          failed = 1'b1;
        end else if (k != SpaceKind) begin
          outs = {outs, make_tok(k, tok_col, int'(cur_col) - int'(tok_col), 1'b0)};
        end
      end
      if (!failed) begin
        tok_col = cur_col;
        nx = advance(Q_START, b);
        if (nx == Q_NONE) begin
          outs = {outs, make_tok(6'd0, cur_col, 0, 1'b1)};
          failed = 1'b1;
        end
      end
    end
    if (failed) begin
      lex_state = Q_START;
      skipping = 1'b1;
    end else begin
      lex_state = nx;
    end
    if (eol) begin
      if (!failed) begin
        k = token_kind_of(lex_state);
        if (lex_state == Q_BANG)
          outs = {outs, make_tok(6'd0, cur_col < 12'd4095 ? cur_col + 12'd1 : 12'd4095,
                                 0, 1'b1)};
        else if (k != NoKind && k != SpaceKind)
          outs = {outs, make_tok(k, tok_col, int'(cur_col) + 1 - int'(tok_col), 1'b0)};
      end
      clear_line();
    end else if (cur_col < ColLimit) begin
      cur_col++;
    end
    n = outs.size();
    if (n > 0) outs[n - 1].last = 1'b1;
    foreach (outs[i]) pending_tokens = {pending_tokens, outs[i]};
  endtask

  task automatic send_byte(logic [7:0] b, logic eol);
    int gap;
    int n;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 5) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.line_end <= eol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(b, eol, n);
  endtask

  function automatic logic [7:0] pick_char();
    string alpha;
    alpha = "abcdeilnprtwNUL0123456789(){}[]&=!<>+-*/%,; \t";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      default: return alpha[$urandom_range(0, alpha.len() - 1)];
    endcase
  endfunction

  task automatic send_line(string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
  endtask

  // directed rows; expected token typed where obvious
  row_t dir_rows[$];
  function automatic void add_row(logic [7:0] c, logic e, logic h = 0, token_t t = '0);
    row_t r;
    r.ch = c;
    r.eol = e;
    r.has_tok = h;
    r.tok = t;
    dir_rows = {dir_rows, r};
  endfunction

  // receiver
  always @(posedge clk) begin
    token_t exp_tok, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
      hold_off = 0;
      hold_used = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.token_kind, out_ch.start_column, out_ch.token_length,
               out_ch.lex_error, out_ch.last};
        if (pending_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %h", got);
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (got !== exp_tok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp k=%0d c=%0d l=%0d e=%b t=%b",
                       exp_tok.kind, exp_tok.col, exp_tok.len, exp_tok.err, exp_tok.last,
                       " got k=%0d c=%0d l=%0d e=%b t=%b",
                       got.kind, got.col, got.len, got.err, got.last);
          end
        end
        rx_wait = $urandom_range(0, 10);
      end
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_off = 200;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    string line;
    int    len;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    in_ch.line_end = 1'b0;
    row_errors = 0;
    hold_req = 1'b0;
    clear_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row("(", 1'b1, 1'b1, with_last(make_tok(6'd3, 12'd0, 1, 1'b0)));
    add_row(8'h00, 1'b1, 1'b1, with_last(make_tok(6'd0, 12'd0, 0, 1'b1)));
    add_row(8'hFF, 1'b1, 1'b1, with_last(make_tok(6'd0, 12'd0, 0, 1'b1)));
    add_row("!", 1'b1, 1'b1, with_last(make_tok(6'd0, 12'd1, 0, 1'b1)));
    line = "nULL New 0a !=//c";
    foreach (line[i]) add_row(line[i], i == line.len() - 1);
    line = "a!b ;";
    foreach (line[i]) add_row(line[i], i == line.len() - 1);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_tok) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_tokens.size() == 0);
        send_byte(dir_rows[i].ch, dir_rows[i].eol);
        if (pending_tokens.size() != 1 || pending_tokens[0] !== dir_rows[i].tok) begin
          row_errors++;
          if (row_errors <= 10) $display("directed row %0d predictor disagrees", i);
        end
      end else begin
        send_byte(dir_rows[i].ch, dir_rows[i].eol);
      end
    end

    words = '{"return", "while", "wain", "int", "if", "else", "println", "NULL",
              "new", "delete", "x1", "0", "42", "==", "<=", ">=", "!=", "//x y"};
    for (int k = 0; k < 1920; ) begin
      if (k >= 600) hold_req = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        line = "";
        repeat ($urandom_range(1, 6)) begin
          line = {line, words[$urandom_range(0, words.size() - 1)]};
          if ($urandom_range(0, 2) != 0) line = {line, " "};
          else line = {line, string'(pick_char())};
        end
      end else begin
        len = $urandom_range(1, 12);
        line = "";
        repeat (len) line = {line, string'(pick_char())};
      end
      for (int i = 0; i < line.len(); i++) begin
        logic [7:0] b;
        b = line[i];
        if ($urandom_range(0, 60) == 0) b = 8'($urandom_range(0, 255));
        send_byte(b, i == line.len() - 1);
        k++;
      end
    end
    send_line("x");
    in_ch.valid <= 1'b0;

    wait (pending_tokens.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && row_errors == 0 && pending_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/mmts_pkg.sv
hdl/mmts_if.sv
hdl/mmts_front.sv
hdl/mmts_queue.sv
hdl/mmts_back.sv
hdl/maximal_munch_token_scanner.sv
verif/tb_token_scanner.sv
